@@ rtl/assert_macros.svh @@
// Assertion macros used by the resampler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define LIR_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("resampler assertion failed");

// A condition that implies another in the same cycle.
`define LIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// A condition that implies another in the next cycle.
`define LIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

@@ rtl/lir_pkg.sv @@
// Package of constants and command/status types for the linear interpolation resampler.
`timescale 1ns / 1ps

package lir_pkg;

  // Sample, rate, counter and configuration widths.
  localparam int SAMPLE_W   = 24;
  localparam int RATE_W     = 18;
  localparam int ERR_W      = RATE_W + 2;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Longest run of outputs one input word may cause.
  localparam int MAX_RUN    = 64;
  localparam int RUN_W      = $clog2(MAX_RUN + 1);

  // Interpolation arithmetic widths.
  localparam int PROD_W     = SAMPLE_W + RATE_W + 1;
  localparam int NUM_W      = PROD_W + 1;
  localparam int MAG_W      = SAMPLE_W + RATE_W;
  localparam int DIV_CNT_W  = $clog2(SAMPLE_W + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 2'd2;

  // Register reset values.
  localparam logic [RATE_W-1:0] FROM_RATE_RST    = 18'd32000;
  localparam logic [RATE_W-1:0] TO_RATE_RST      = 18'd32000;
  localparam logic [CNT_W-1:0]  OUTPUT_LIMIT_RST = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul0;
    logic mul1;
    logic add;
    logic div_start;
    logic step;
    logic emit;
    logic finish;
  } lir_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic e_neg;
    logic e_zero;
    logic run_full;
    logic suppressed;
    logic out_free;
    logic div_done;
  } lir_sts_t;

endpackage

@@ rtl/linear_interp_resampler_top.sv @@
// Top level: an input word is accepted while idle; the outputs it causes then follow in turn.
// An output at zero time error goes straight to the output register; an interpolated one
// passes the multiplies, the add and the 24-step restoring divider that divides by the
// target rate, one quotient bit a cycle. A word holds the block until its run ends: its
// outputs, each step held back by the limit, and any wait for room in the output register.
// Synchronous active-low reset restores the default rates, the output limit, and clears
// the previous sample, the time error and the output count; no memory needs clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_interp_resampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lir_pkg::SAMPLE_W-1:0]        in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_last_of_run
);

  lir_pkg::lir_cmd_t cmd;
  lir_pkg::lir_sts_t sts;

  // Sequencing of words and runs.
  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register.
  lir_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .sts             (sts)
  );

  // The controller issues at most one command at a time.
  `LIR_ASSERT(a_cmd_onehot, clk, rst_n, $onehot0(cmd))
  // A word is only loaded into the output register when it has room.
  `LIR_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  // Once a word is accepted the block is busy with it in the next cycle.
  `LIR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

@@ rtl/lir_div.sv @@
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps

module lir_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lir_pkg::MAG_W-1:0]     dividend,
  input  logic [lir_pkg::RATE_W-1:0]    divisor,
  output logic [lir_pkg::SAMPLE_W-1:0]  quotient,
  output logic                          done
);

  logic [lir_pkg::RATE_W-1:0]    rem_r, rem_nxt;
  logic [lir_pkg::SAMPLE_W-1:0]  quo_r, quo_nxt;
  logic [lir_pkg::RATE_W-1:0]    dsr_r;
  logic [lir_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [lir_pkg::RATE_W:0]      shifted;
  logic [lir_pkg::RATE_W+1:0]    trial;

  // The dividend is below divisor times two to the sample width, so its top
  // bits already form a partial remainder smaller than the divisor.
  assign shifted = {rem_r, quo_r[lir_pkg::SAMPLE_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = dividend[lir_pkg::MAG_W-1:lir_pkg::SAMPLE_W];
      quo_nxt  = dividend[lir_pkg::SAMPLE_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial[lir_pkg::RATE_W+1]) begin
        rem_nxt = shifted[lir_pkg::RATE_W-1:0];
        quo_nxt = {quo_r[lir_pkg::SAMPLE_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[lir_pkg::RATE_W-1:0];
        quo_nxt = {quo_r[lir_pkg::SAMPLE_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lir_pkg::DIV_CNT_W'(lir_pkg::SAMPLE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags are reset; the arithmetic registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ rtl/lir_ctrl.sv @@
// Controller state machine that sequences each input word and its run of outputs.
`timescale 1ns / 1ps

module lir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lir_pkg::lir_sts_t  sts,
  output lir_pkg::lir_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CHECK    = 3'd1;
  localparam logic [2:0] ST_MUL0     = 3'd2;
  localparam logic [2:0] ST_MUL1     = 3'd3;
  localparam logic [2:0] ST_ADD      = 3'd4;
  localparam logic [2:0] ST_DIV_GO   = 3'd5;
  localparam logic [2:0] ST_DIV_WAIT = 3'd6;
  localparam logic [2:0] ST_EMIT     = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.e_neg || sts.run_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.suppressed) begin
          // Output limit reached: time still advances, nothing is produced.
          cmd.step = 1'b1;
        end else if (sts.e_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

@@ rtl/lir_dp.sv @@
// Datapath: configuration, time error, interpolation arithmetic and output register.
`timescale 1ns / 1ps

module lir_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [lir_pkg::SAMPLE_W-1:0]        in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_last_of_run,
  input  lir_pkg::lir_cmd_t                   cmd,
  output lir_pkg::lir_sts_t                   sts
);

  localparam int TMAX_W = lir_pkg::RATE_W + lir_pkg::RUN_W;

  // Configuration registers.
  logic [lir_pkg::RATE_W-1:0] from_rate_r;
  logic [lir_pkg::RATE_W-1:0] to_rate_r;
  logic [lir_pkg::CNT_W-1:0]  out_limit_r;

  // Stream state kept between words.
  logic signed [lir_pkg::SAMPLE_W-1:0] prev_r;
  logic signed [lir_pkg::ERR_W-1:0]    terr_r;
  logic [lir_pkg::CNT_W-1:0]           out_cnt_r;
  logic                                started_r;

  // Working registers of the word in progress.
  logic signed [lir_pkg::SAMPLE_W-1:0] y0_r, y1_r;
  logic signed [lir_pkg::ERR_W-1:0]    e_r;
  logic [lir_pkg::RATE_W-1:0]          from_eff_r, to_eff_r;
  logic [lir_pkg::RUN_W-1:0]           iter_r;
  logic signed [lir_pkg::PROD_W-1:0]   p1_r, p2_r;
  logic                                num_neg_r;
  logic [lir_pkg::MAG_W-1:0]           num_mag_r;

  // Output register.
  logic                                out_valid_r;
  logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                out_last_r;

  logic [lir_pkg::RATE_W-1:0]          from_eff, to_in, to_eff;
  logic [TMAX_W-1:0]                   to_max;
  logic signed [lir_pkg::RATE_W:0]     e_op, d_op;
  logic [lir_pkg::RATE_W-1:0]          to_minus_e;
  logic signed [lir_pkg::PROD_W-1:0]   p1_nxt, p2_nxt;
  logic signed [lir_pkg::NUM_W-1:0]    num;
  logic [lir_pkg::NUM_W-1:0]           num_abs;
  logic [lir_pkg::SAMPLE_W-1:0]        quo;
  logic                                div_done;
  logic signed [lir_pkg::SAMPLE_W-1:0] interp;
  logic                                last_nxt;

  // Effective rates: zero reads as one, and to is capped at MAX_RUN times from.
  assign from_eff = (from_rate_r == '0) ? lir_pkg::RATE_W'(1) : from_rate_r;
  assign to_in    = (to_rate_r == '0) ? lir_pkg::RATE_W'(1) : to_rate_r;
  assign to_max   = TMAX_W'(from_eff) * TMAX_W'(lir_pkg::MAX_RUN);
  assign to_eff   = (TMAX_W'(to_in) > to_max) ? lir_pkg::RATE_W'(to_max) : to_in;

  // Interpolation terms: y0*e + y1*(to - e), with 0 < e < to.
  assign to_minus_e = to_eff_r - e_r[lir_pkg::RATE_W-1:0];
  assign e_op       = {1'b0, e_r[lir_pkg::RATE_W-1:0]};
  assign d_op       = {1'b0, to_minus_e};
  assign p1_nxt     = lir_pkg::PROD_W'(y0_r) * lir_pkg::PROD_W'(e_op);
  assign p2_nxt     = lir_pkg::PROD_W'(y1_r) * lir_pkg::PROD_W'(d_op);
  assign num        = lir_pkg::NUM_W'(p1_r) + lir_pkg::NUM_W'(p2_r);
  assign num_abs    = num[lir_pkg::NUM_W-1] ? -num : num;

  // The divider works on the magnitude; the sign goes back on afterwards.
  lir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_mag_r),
    .divisor  (to_eff_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign interp = num_neg_r ? -$signed(quo) : $signed(quo);

  // A word is the last of its run when the loop ends after it or the limit stops
  // every later one.
  assign last_nxt = (e_r[lir_pkg::RATE_W-1:0] < from_eff_r) ||
                    (iter_r == lir_pkg::RUN_W'(lir_pkg::MAX_RUN - 1)) ||
                    ((out_cnt_r + 1'b1) == out_limit_r);

  // Configuration and stream state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_rate_r <= lir_pkg::FROM_RATE_RST;
      to_rate_r   <= lir_pkg::TO_RATE_RST;
      out_limit_r <= lir_pkg::OUTPUT_LIMIT_RST;
      prev_r      <= '0;
      terr_r      <= '0;
      out_cnt_r   <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lir_pkg::CFG_FROM_RATE:    from_rate_r <= cfg_data[lir_pkg::RATE_W-1:0];
          lir_pkg::CFG_TO_RATE:      to_rate_r   <= cfg_data[lir_pkg::RATE_W-1:0];
          lir_pkg::CFG_OUTPUT_LIMIT: out_limit_r <= cfg_data[lir_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        prev_r    <= $signed(in_sample);
        started_r <= 1'b1;
      end
      if (cmd.finish) begin
        terr_r <= e_r[lir_pkg::ERR_W-1] ? e_r : '1;
      end
      if (cmd.emit) begin
        out_cnt_r <= out_cnt_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Run counters: loaded on accept, advanced on every iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r    <= '0;
      iter_r <= '0;
    end else if (cmd.accept) begin
      e_r    <= started_r ? terr_r + lir_pkg::ERR_W'(to_eff) : terr_r;
      iter_r <= '0;
    end else if (cmd.step || cmd.emit) begin
      e_r    <= e_r - lir_pkg::ERR_W'(from_eff_r);
      iter_r <= iter_r + 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      y0_r       <= prev_r;
      y1_r       <= $signed(in_sample);
      from_eff_r <= from_eff;
      to_eff_r   <= to_eff;
    end
    if (cmd.mul0) begin
      p1_r <= p1_nxt;
    end
    if (cmd.mul1) begin
      p2_r <= p2_nxt;
    end
    if (cmd.add) begin
      num_neg_r <= num[lir_pkg::NUM_W-1];
      num_mag_r <= num_abs[lir_pkg::MAG_W-1:0];
    end
    if (cmd.emit) begin
      out_sample_r <= (e_r == '0) ? y1_r : interp;
      out_last_r   <= last_nxt;
    end
  end

  // Status to the controller.
  assign sts.e_neg      = e_r[lir_pkg::ERR_W-1];
  assign sts.e_zero     = (e_r == '0);
  assign sts.run_full   = (iter_r == lir_pkg::RUN_W'(lir_pkg::MAX_RUN));
  assign sts.suppressed = (out_cnt_r >= out_limit_r);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.div_done   = div_done;

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_of_run = out_last_r;

endmodule
